// File: design/fsac_pkg.sv
`default_nettype none

// Shared types and constants of the sorted alpha composite block.
package fsac_pkg;

    // Default fragment capacity of one pixel.
    localparam int MAX_FRAGS_DEF = 16;

    // Depth of the queues that part the front, back and result sides.
    localparam int QUEUE_DEPTH = 2;

    // Field widths.
    localparam int DEPTH_W = 24;
    localparam int COL_W   = 8;
    localparam int ACC_W   = 16;
    localparam int KEY_W   = DEPTH_W + 4 * COL_W;

    // Request codes.
    localparam logic REQ_BASE = 1'b0;
    localparam logic REQ_FRAG = 1'b1;

    // Flipping every bit but the sign turns signed depth into a key that
    // sorts far fragments first under an unsigned ascending compare.
    localparam logic [DEPTH_W-1:0] DEPTH_FLIP = 24'h7F_FFFF;

    // Blend step: dst = (c*257*a + dst*(255-a) + 127) / 255. The numerator
    // stays below 2^24, so a multiply by ceil(2^33/255) and a shift is exact.
    localparam int               NUM_W            = 25;
    localparam int               RECIP_255_W      = 26;
    localparam int               RECIP_255_SHIFT  = 33;
    localparam int               PROD_255_W       = NUM_W + RECIP_255_W;
    localparam logic [NUM_W-1:0] ROUND_255        = 25'd127;
    localparam logic [RECIP_255_W-1:0] RECIP_255  = 26'd33686019;

    // Output conversion: out = (2*dst + 257) / 514, by ceil(2^28/514).
    localparam int                OUT_NUM_W        = ACC_W + 2;
    localparam int                RECIP_514_W      = 20;
    localparam int                RECIP_514_SHIFT  = 28;
    localparam int                PROD_514_W       = OUT_NUM_W + RECIP_514_W;
    localparam logic [OUT_NUM_W-1:0]   HALF_514    = 18'd257;
    localparam logic [RECIP_514_W-1:0] RECIP_514   = 20'd522248;

    // Sort key: ascending order gives depth descending, then colour and
    // alpha ascending.
    typedef struct packed {
        logic [DEPTH_W-1:0] far_first;
        logic [COL_W-1:0]   red;
        logic [COL_W-1:0]   green;
        logic [COL_W-1:0]   blue;
        logic [COL_W-1:0]   alpha;
    } t_key;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic req;
        logic last;
        t_key key;
    } t_item;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_rgb;

    // One result transaction.
    typedef struct packed {
        t_rgb colour;
        logic dropped;
    } t_result;

    // Commands to the sorted fragment row.
    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_row_ctl;

    // Stage strobes of one blend lane.
    typedef struct packed {
        logic load_base;
        logic mul;
        logic sum;
        logic div;
        logic fin;
    } t_blend_ctl;

    // Status of the back end, watched by the checks at the top level.
    typedef struct packed {
        logic idle;
        logic take;
        logic res_push;
        logic res_full;
    } t_back_stat;

endpackage

`default_nettype wire

// File: design/fragment_sort_alpha_composite.sv
// Resolves one pixel of an order-independent transparency buffer.
// Input side is a queue: an item transaction completes when push is high and
// full is low. A base item (req_type 0) loads the opaque colour and starts a
// pixel; fragment items (req_type 1) are inserted into a sorted row of
// MAX_FRAGS entries as they arrive, one per cycle while no resolve runs;
// extra fragments are dropped and flagged. An item with last_frag set
// resolves the pixel. Result side is a queue: the oldest result is on the
// o_ ports while empty is low and is taken when pop is high. Only last-marked
// items give a result. A base or non-last fragment item is applied as the
// back end takes it. A resolve walks the stored fragments through the
// three-stage blend step one at a time, as the result of each step feeds
// the next fragment, and no new item is taken until the result is pushed.
// A two-entry queue on each side lets input and output stall on their own:
// while the receiver does not pop, results gather in the output queue, and
// when that is full the back end waits and the input queue fills, raising
// full. Synchronous reset empties both queues and clears the fragment
// count, the overflow flag and the base colour.
`default_nettype none

module fragment_sort_alpha_composite #(
    parameter int MAX_FRAGS = fsac_pkg::MAX_FRAGS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                i_req_type,
    input  wire logic signed [fsac_pkg::DEPTH_W-1:0] i_frag_depth,
    input  wire logic [fsac_pkg::COL_W-1:0]          i_in_red,
    input  wire logic [fsac_pkg::COL_W-1:0]          i_in_green,
    input  wire logic [fsac_pkg::COL_W-1:0]          i_in_blue,
    input  wire logic [fsac_pkg::COL_W-1:0]          i_frag_alpha,
    input  wire logic                                i_last_frag,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [fsac_pkg::COL_W-1:0]               o_out_red,
    output logic [fsac_pkg::COL_W-1:0]               o_out_green,
    output logic [fsac_pkg::COL_W-1:0]               o_out_blue,
    output logic                                     o_dropped_flag
);

    localparam int CNT_W = $clog2(MAX_FRAGS + 1);

    fsac_pkg::t_item      w_item;
    logic                 w_item_valid;
    logic                 w_take;
    fsac_pkg::t_result    w_result;
    fsac_pkg::t_back_stat w_stat;
    logic [CNT_W-1:0]     w_count;

    // Front end: key forming and input queue.
    fsac_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_req_type   (i_req_type),
        .i_frag_depth (i_frag_depth),
        .i_in_red     (i_in_red),
        .i_in_green   (i_in_green),
        .i_in_blue    (i_in_blue),
        .i_frag_alpha (i_frag_alpha),
        .i_last_frag  (i_last_frag),
        .i_pop        (w_take),
        .o_item       (w_item),
        .o_valid      (w_item_valid)
    );

    // Back end: sorted store, blend lanes and result queue.
    fsac_back #(
        .MAX_FRAGS (MAX_FRAGS),
        .CNT_W     (CNT_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_item),
        .i_valid  (w_item_valid),
        .o_take   (w_take),
        .o_result (w_result),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_stat   (w_stat),
        .o_count  (w_count)
    );

    assign o_out_red      = w_result.colour.red;
    assign o_out_green    = w_result.colour.green;
    assign o_out_blue     = w_result.colour.blue;
    assign o_dropped_flag = w_result.dropped;

`ifndef SYNTHESIS
    // Both queues come out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // The back end never pushes a result into a full result queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_push |-> !w_stat.res_full)
        else $error("result pushed into full queue");

    // Two results are always separated by at least the conversion stages.
    a_push_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_push |=> !w_stat.res_push)
        else $error("back-to-back result pushes");

    // The fragment count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(MAX_FRAGS))
        else $error("fragment count above capacity");

    // Items are taken from the input queue only between resolves.
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.take |-> (w_stat.idle && w_item_valid))
        else $error("item taken while resolving");
`endif

endmodule

`default_nettype wire

// File: design/fsac_fifo.sv
`default_nettype none

// Small first-in first-out queue with registered storage.
module fsac_fifo #(
    parameter int W     = 1,
    parameter int DEPTH = fsac_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [AW:0]  r_wr_ptr;
    logic [AW:0]  r_rd_ptr;
    logic         w_do_push;
    logic         w_do_pop;

    // Pointers carry one extra bit to tell full from empty.
    assign o_empty   = (r_wr_ptr == r_rd_ptr);
    assign o_full    = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                       (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rd_ptr[AW-1:0]];

    // Pointer update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// File: design/fsac_front.sv
`default_nettype none

// Front end: accepts items, builds the sort key and queues them for the back.
module fsac_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    output logic                                   o_full,
    input  wire logic                              i_req_type,
    input  wire logic signed [fsac_pkg::DEPTH_W-1:0] i_frag_depth,
    input  wire logic [fsac_pkg::COL_W-1:0]        i_in_red,
    input  wire logic [fsac_pkg::COL_W-1:0]        i_in_green,
    input  wire logic [fsac_pkg::COL_W-1:0]        i_in_blue,
    input  wire logic [fsac_pkg::COL_W-1:0]        i_frag_alpha,
    input  wire logic                              i_last_frag,
    input  wire logic                              i_pop,
    output fsac_pkg::t_item                        o_item,
    output logic                                   o_valid
);

    fsac_pkg::t_item                         w_item;
    logic [$bits(fsac_pkg::t_item)-1:0]      w_rdata;
    logic                                    w_empty;

    // Classify the item and form its key; a base item carries its colour in
    // the colour fields of the key.
    always_comb begin
        w_item.req             = i_req_type;
        w_item.last            = i_last_frag;
        w_item.key.far_first   = i_frag_depth ^ fsac_pkg::DEPTH_FLIP;
        w_item.key.red         = i_in_red;
        w_item.key.green       = i_in_green;
        w_item.key.blue        = i_in_blue;
        w_item.key.alpha       = i_frag_alpha;
    end

    fsac_fifo #(
        .W     ($bits(fsac_pkg::t_item)),
        .DEPTH (fsac_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (w_item),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_rdata (w_rdata),
        .o_empty (w_empty)
    );

    assign o_item  = fsac_pkg::t_item'(w_rdata);
    assign o_valid = !w_empty;

endmodule

`default_nettype wire

// File: design/fsac_sort_row.sv
`default_nettype none

// Row of key registers kept in ascending order. A new key is inserted by a
// parallel compare in every cell; the resolve walk shifts the row towards
// cell zero, one fragment per step.
module fsac_sort_row #(
    parameter int MAX_FRAGS = fsac_pkg::MAX_FRAGS_DEF,
    parameter int CNT_W     = $clog2(MAX_FRAGS + 1)
) (
    input  wire logic                        i_clk,
    input  wire fsac_pkg::t_row_ctl          i_ctl,
    input  wire logic [fsac_pkg::KEY_W-1:0]  i_key,
    input  wire logic [CNT_W-1:0]            i_count,
    output logic [fsac_pkg::KEY_W-1:0]       o_head
);

    logic [fsac_pkg::KEY_W-1:0] r_key  [MAX_FRAGS];
    logic [fsac_pkg::KEY_W-1:0] n_key  [MAX_FRAGS];
    logic [MAX_FRAGS-1:0]       w_gt;

    for (genvar g = 0; g < MAX_FRAGS; g++) begin : g_cell
        logic                       w_prev_gt;
        logic [fsac_pkg::KEY_W-1:0] w_prev_key;
        logic [fsac_pkg::KEY_W-1:0] w_succ_key;

        // A stored key larger than the new one moves up by one place.
        assign w_gt[g] = (CNT_W'(g) < i_count) && (r_key[g] > i_key);

        if (g == 0) begin : g_first
            assign w_prev_gt  = 1'b0;
            assign w_prev_key = i_key;
        end else begin : g_inner
            assign w_prev_gt  = w_gt[g-1];
            assign w_prev_key = r_key[g-1];
        end

        if (g == MAX_FRAGS - 1) begin : g_last
            assign w_succ_key = r_key[g];
        end else begin : g_body
            assign w_succ_key = r_key[g+1];
        end

        // Next value of this cell.
        always_comb begin
            n_key[g] = r_key[g];
            if (i_ctl.insert) begin
                if (w_prev_gt) begin
                    n_key[g] = w_prev_key;
                end else if (w_gt[g] || (CNT_W'(g) == i_count)) begin
                    n_key[g] = i_key;
                end
            end else if (i_ctl.shift_out) begin
                n_key[g] = w_succ_key;
            end
        end

        always_ff @(posedge i_clk) begin
            r_key[g] <= n_key[g];
        end
    end

    assign o_head = r_key[0];

endmodule

`default_nettype wire

// File: design/fsac_blend.sv
`default_nettype none

// One colour lane of the compositor. A blend step runs in three stages:
// products, numerator sum, then division by 255 through a reciprocal
// multiply. A fourth strobe converts the 16-bit result to 8 bits.
module fsac_blend (
    input  wire logic                        i_clk,
    input  wire fsac_pkg::t_blend_ctl        i_ctl,
    input  wire logic [fsac_pkg::COL_W-1:0]  i_base,
    input  wire logic [fsac_pkg::COL_W-1:0]  i_col,
    input  wire logic [fsac_pkg::COL_W-1:0]  i_alpha,
    output logic [fsac_pkg::COL_W-1:0]       o_out
);

    localparam int PW = 2 * fsac_pkg::COL_W;
    localparam int DW = fsac_pkg::ACC_W + fsac_pkg::COL_W;

    logic [fsac_pkg::ACC_W-1:0]       r_dst;
    logic [PW-1:0]                    r_ca;
    logic [DW-1:0]                    r_dp;
    logic [fsac_pkg::NUM_W-1:0]       r_num;
    logic [fsac_pkg::COL_W-1:0]       r_out;
    logic [fsac_pkg::COL_W-1:0]       w_inv_a;
    logic [fsac_pkg::PROD_255_W-1:0]  w_prod;
    logic [fsac_pkg::OUT_NUM_W-1:0]   w_n2;
    logic [fsac_pkg::PROD_514_W-1:0]  w_p2;
    logic [fsac_pkg::COL_W:0]         w_v9;

    // 255 - a is the bitwise inverse for an 8-bit alpha.
    assign w_inv_a = ~i_alpha;

    // Reciprocal multiplies for the blend division and the output scaling.
    assign w_prod = fsac_pkg::PROD_255_W'(r_num) *
                    fsac_pkg::PROD_255_W'(fsac_pkg::RECIP_255);
    assign w_n2   = {1'b0, r_dst, 1'b0} + fsac_pkg::HALF_514;
    assign w_p2   = fsac_pkg::PROD_514_W'(w_n2) *
                    fsac_pkg::PROD_514_W'(fsac_pkg::RECIP_514);
    assign w_v9   = w_p2[fsac_pkg::RECIP_514_SHIFT +: (fsac_pkg::COL_W + 1)];

    // Accumulator and stage registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_base) begin
            r_dst <= {i_base, i_base};
        end else if (i_ctl.div) begin
            r_dst <= w_prod[fsac_pkg::RECIP_255_SHIFT +: fsac_pkg::ACC_W];
        end
        if (i_ctl.mul) begin
            r_ca <= PW'(i_col) * PW'(i_alpha);
            r_dp <= DW'(r_dst) * DW'(w_inv_a);
        end
        if (i_ctl.sum) begin
            r_num <= {1'b0, r_ca, {fsac_pkg::COL_W{1'b0}}} +
                     fsac_pkg::NUM_W'(r_ca) + fsac_pkg::NUM_W'(r_dp) +
                     fsac_pkg::ROUND_255;
        end
        if (i_ctl.fin) begin
            r_out <= (w_v9 > (fsac_pkg::COL_W + 1)'(255)) ? '1
                                                          : w_v9[fsac_pkg::COL_W-1:0];
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// File: design/fsac_back.sv
`default_nettype none

// Back end: applies queued items to the pixel state, keeps fragments sorted
// and on the last item walks them through the blend lanes.
module fsac_back #(
    parameter int MAX_FRAGS = fsac_pkg::MAX_FRAGS_DEF,
    parameter int CNT_W     = $clog2(MAX_FRAGS + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire fsac_pkg::t_item  i_item,
    input  wire logic             i_valid,
    output logic                  o_take,
    output fsac_pkg::t_result     o_result,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output fsac_pkg::t_back_stat  o_stat,
    output logic [CNT_W-1:0]      o_count
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_WALK_MUL = 3'd1;
    localparam logic [2:0] S_WALK_SUM = 3'd2;
    localparam logic [2:0] S_WALK_DIV = 3'd3;
    localparam logic [2:0] S_FIN_MUL  = 3'd4;
    localparam logic [2:0] S_FIN_PUSH = 3'd5;

    logic [2:0]                          r_state;
    logic [2:0]                          n_state;
    logic [CNT_W-1:0]                    r_count;
    logic [CNT_W-1:0]                    n_count;
    fsac_pkg::t_rgb                      r_base;
    fsac_pkg::t_rgb                      n_base;
    logic                                r_ovf;
    logic                                n_ovf;
    logic                                w_take;
    logic                                w_is_frag;
    logic                                w_room;
    logic                                w_res_push;
    logic                                w_res_full;
    fsac_pkg::t_row_ctl                  w_row_ctl;
    fsac_pkg::t_blend_ctl                w_blend_ctl;
    fsac_pkg::t_key                      w_head;
    fsac_pkg::t_result                   w_res_in;
    logic [$bits(fsac_pkg::t_result)-1:0] w_res_out;
    logic [fsac_pkg::COL_W-1:0]          w_out_red;
    logic [fsac_pkg::COL_W-1:0]          w_out_green;
    logic [fsac_pkg::COL_W-1:0]          w_out_blue;

    assign w_take    = (r_state == S_IDLE) && i_valid;
    assign w_is_frag = (i_item.req == fsac_pkg::REQ_FRAG);
    assign w_room    = (r_count < CNT_W'(MAX_FRAGS));

    // Pixel state and sequencing of the resolve walk.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_base     = r_base;
        n_ovf      = r_ovf;
        w_res_push = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (!w_is_frag) begin
                        n_base.red   = i_item.key.red;
                        n_base.green = i_item.key.green;
                        n_base.blue  = i_item.key.blue;
                        n_count      = '0;
                        n_ovf        = 1'b0;
                    end else if (w_room) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.last) begin
                        n_state = (n_count == '0) ? S_FIN_MUL : S_WALK_MUL;
                    end
                end
            end
            S_WALK_MUL: begin
                n_count = r_count - 1'b1;
                n_state = S_WALK_SUM;
            end
            S_WALK_SUM: begin
                n_state = S_WALK_DIV;
            end
            S_WALK_DIV: begin
                n_state = (r_count == '0) ? S_FIN_MUL : S_WALK_MUL;
            end
            S_FIN_MUL: begin
                n_state = S_FIN_PUSH;
            end
            S_FIN_PUSH: begin
                if (!w_res_full) begin
                    w_res_push = 1'b1;
                    n_count    = '0;
                    n_ovf      = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_base  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_base  <= n_base;
            r_ovf   <= n_ovf;
        end
    end

    // Row and lane commands.
    assign w_row_ctl.insert    = w_take && w_is_frag && w_room;
    assign w_row_ctl.shift_out = (r_state == S_WALK_MUL);

    assign w_blend_ctl.load_base = w_take && i_item.last;
    assign w_blend_ctl.mul       = (r_state == S_WALK_MUL);
    assign w_blend_ctl.sum       = (r_state == S_WALK_SUM);
    assign w_blend_ctl.div       = (r_state == S_WALK_DIV);
    assign w_blend_ctl.fin       = (r_state == S_FIN_MUL);

    fsac_sort_row #(
        .MAX_FRAGS (MAX_FRAGS),
        .CNT_W     (CNT_W)
    ) u_row (
        .i_clk   (i_clk),
        .i_ctl   (w_row_ctl),
        .i_key   (i_item.key),
        .i_count (r_count),
        .o_head  (w_head)
    );

    fsac_blend u_lane_red (
        .i_clk   (i_clk),
        .i_ctl   (w_blend_ctl),
        .i_base  (n_base.red),
        .i_col   (w_head.red),
        .i_alpha (w_head.alpha),
        .o_out   (w_out_red)
    );

    fsac_blend u_lane_green (
        .i_clk   (i_clk),
        .i_ctl   (w_blend_ctl),
        .i_base  (n_base.green),
        .i_col   (w_head.green),
        .i_alpha (w_head.alpha),
        .o_out   (w_out_green)
    );

    fsac_blend u_lane_blue (
        .i_clk   (i_clk),
        .i_ctl   (w_blend_ctl),
        .i_base  (n_base.blue),
        .i_col   (w_head.blue),
        .i_alpha (w_head.alpha),
        .o_out   (w_out_blue)
    );

    // Result queue towards the receiver.
    assign w_res_in.colour.red   = w_out_red;
    assign w_res_in.colour.green = w_out_green;
    assign w_res_in.colour.blue  = w_out_blue;
    assign w_res_in.dropped      = r_ovf;

    fsac_fifo #(
        .W     ($bits(fsac_pkg::t_result)),
        .DEPTH (fsac_pkg::QUEUE_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_rdata (w_res_out),
        .o_empty (o_empty)
    );

    assign o_result = fsac_pkg::t_result'(w_res_out);
    assign o_take   = w_take;
    assign o_count  = r_count;

    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.take     = w_take;
    assign o_stat.res_push = w_res_push;
    assign o_stat.res_full = w_res_full;

endmodule

`default_nettype wire
